>>> rtl/mrfp_pkg.sv
// ----------------------------------------------------------------------------
// mrfp_pkg
// Types and constants shared by the relocation field patch block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mrfp_pkg;

    // relocation kinds
    localparam logic [4:0] K_NONE          = 5'd0;
    localparam logic [4:0] K_ABS32         = 5'd1;
    localparam logic [4:0] K_PC32          = 5'd2;
    localparam logic [4:0] K_J26           = 5'd3;
    localparam logic [4:0] K_MM_J26        = 5'd4;
    localparam logic [4:0] K_HI16          = 5'd5;
    localparam logic [4:0] K_MM_HI16       = 5'd6;
    localparam logic [4:0] K_LO16          = 5'd7;
    localparam logic [4:0] K_MM_LO16       = 5'd8;
    localparam logic [4:0] K_GOT16         = 5'd9;
    localparam logic [4:0] K_MM_GOT16      = 5'd10;
    localparam logic [4:0] K_PC7           = 5'd11;
    localparam logic [4:0] K_PC10          = 5'd12;
    localparam logic [4:0] K_PC16          = 5'd13;
    localparam logic [4:0] K_PC23          = 5'd14;
    localparam logic [4:0] K_TPREL_HI16    = 5'd15;
    localparam logic [4:0] K_TPREL_LO16    = 5'd16;
    localparam logic [4:0] K_MM_TPREL_HI16 = 5'd17;
    localparam logic [4:0] K_MM_TPREL_LO16 = 5'd18;
    localparam logic [4:0] K_GPREL16       = 5'd19;
    localparam logic [4:0] K_GPREL32       = 5'd20;
    localparam logic [4:0] K_ABS32HI16     = 5'd21;
    localparam logic [4:0] K_GLOBAL_J26    = 5'd22;
    localparam logic [4:0] K_MM_GLOBAL_J26 = 5'd23;
    localparam logic [4:0] K_PLAIN_HI16    = 5'd24;
    localparam logic [4:0] K_PLAIN_LO16    = 5'd25;

    // result status codes
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_UNHANDLED    = 3'd1;
    localparam logic [2:0] ST_BAD_BIT0     = 3'd2;
    localparam logic [2:0] ST_UNALIGNED    = 3'd3;
    localparam logic [2:0] ST_BAD_OPCODE   = 3'd4;
    localparam logic [2:0] ST_PC23_RANGE   = 3'd5;

    // jump opcodes
    localparam logic [5:0] OP_JAL          = 6'h03;
    localparam logic [5:0] OP_JALX         = 6'h1d;
    localparam logic [5:0] OP_MM_JAL       = 6'h3d;
    localparam logic [5:0] OP_MM_JALX      = 6'h3c;

    // rounding offset for the high halfword forms
    localparam logic [15:0] HI_ROUND       = 16'h8000;

    // how the back end places the computed value into the word
    typedef enum logic [3:0] {
        PL_KEEP,
        PL_FULL,
        PL_J26,
        PL_HI,
        PL_LO,
        PL_PC7,
        PL_PC10,
        PL_PC16,
        PL_PC23,
        PL_AHI
    } t_place;

    typedef struct packed {
        logic [4:0]         func;
        logic [31:0]        insn_word;
        logic [31:0]        place_address;
        logic [31:0]        target_address;
        logic signed [31:0] addend;
        logic               target_defined;
        logic               target_micro;
        logic               target_is_gp_disp;
    } t_in;

    typedef struct packed {
        logic [31:0] patched_word;
        logic [2:0]  status;
    } t_out;

    // classified record handed from front to back
    typedef struct packed {
        logic [31:0] word;
        logic [31:0] ins;
        logic [31:0] s_val;
        logic [31:0] y_val;
        logic [31:0] z_val;
        logic        sub_z;
        logic [15:0] k_val;
        t_place      place;
        logic        sh2;
        logic        swap;
        logic [2:0]  status;
    } t_job;

endpackage

`default_nettype wire

>>> rtl/mrfp_front.sv
// ----------------------------------------------------------------------------
// mrfp_front
// Classifies a relocation request: halfword swap, cross-mode jump check and
// opcode rewrite, and the operand terms that the back end adds up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mrfp_front (
    input  mrfp_pkg::t_in  i_item,
    input  logic [31:0]    i_gp_address,
    output mrfp_pkg::t_job o_job
);
    import mrfp_pkg::*;

    logic [4:0]  kind;
    logic [31:0] word;
    logic [31:0] addr_a;
    logic [31:0] ins0;
    logic        tmic;
    logic        gpd;
    logic        swap;
    logic        cross_to_m;
    logic        cross_to_r;
    logic        cross_jmp;
    logic [5:0]  op;
    logic [5:0]  native_op;
    logic [5:0]  cross_op;
    logic [31:0] s_val;
    logic [31:0] p_plus4;
    logic [31:0] jmask;
    logic        sh2;

    assign kind   = i_item.func;
    assign word   = i_item.insn_word;
    assign addr_a = i_item.addend;
    assign tmic   = i_item.target_defined & i_item.target_micro;
    assign gpd    = i_item.target_is_gp_disp;

    // microMIPS kinds work on the halfword-swapped word
    always_comb begin
        case (kind) inside
            K_MM_J26, K_MM_HI16, K_MM_LO16, K_MM_GOT16, K_PC16, K_PC23,
            K_MM_TPREL_HI16, K_MM_TPREL_LO16, K_MM_GLOBAL_J26: swap = 1'b1;
            default: swap = 1'b0;
        endcase
    end

    assign ins0  = swap ? {word[15:0], word[31:16]} : word;
    assign s_val = i_item.target_address | {31'b0, tmic};

    // jumps between the two instruction sets
    assign cross_to_m = i_item.target_defined & tmic &
                        ((kind == K_J26) | (kind == K_GLOBAL_J26));
    assign cross_to_r = i_item.target_defined & ~tmic &
                        ((kind == K_MM_J26) | (kind == K_MM_GLOBAL_J26));
    assign cross_jmp  = cross_to_m | cross_to_r;
    assign op         = ins0[31:26];
    assign native_op  = cross_to_m ? OP_JAL  : OP_MM_JAL;
    assign cross_op   = cross_to_m ? OP_JALX : OP_MM_JALX;

    // jump field shift: word-aligned unless a microMIPS jump stays in mode
    assign sh2     = (kind == K_J26) | (kind == K_GLOBAL_J26) | cross_jmp;
    assign p_plus4 = i_item.place_address + 32'd4;
    assign jmask   = sh2 ? 32'hf000_0000 : 32'hf800_0000;

    // status, rewritten word and operand terms: r = s + y - z + k
    always_comb begin
        o_job.word   = word;
        o_job.ins    = ins0;
        o_job.status = ST_OK;
        if (cross_jmp) begin
            if (s_val[0] != cross_to_m) begin
                o_job.status = ST_BAD_BIT0;
            end else if (s_val[1]) begin
                o_job.status = ST_UNALIGNED;
            end else if ((op != native_op) && (op != cross_op)) begin
                o_job.status = ST_BAD_OPCODE;
            end else begin
                o_job.ins = {cross_op, ins0[25:0]};
            end
        end else if (kind > K_PLAIN_LO16) begin
            o_job.status = ST_UNHANDLED;
        end

        o_job.s_val = s_val;
        o_job.swap  = swap;
        o_job.sh2   = sh2;
        o_job.y_val = addr_a;
        o_job.z_val = i_item.place_address;
        o_job.sub_z = 1'b0;
        o_job.k_val = 16'h0000;
        o_job.place = PL_KEEP;
        case (kind)
            K_ABS32: begin
                o_job.place = PL_FULL;
            end
            K_PC32: begin
                o_job.sub_z = 1'b1;
                o_job.place = PL_FULL;
            end
            K_J26, K_MM_J26: begin
                o_job.y_val = addr_a | (p_plus4 & jmask);
                o_job.place = PL_J26;
            end
            K_HI16, K_MM_HI16: begin
                o_job.sub_z = gpd;
                o_job.k_val = HI_ROUND;
                o_job.place = PL_HI;
            end
            K_LO16: begin
                o_job.sub_z = gpd;
                o_job.k_val = gpd ? 16'd4 : 16'd0;
                o_job.place = PL_LO;
            end
            K_MM_LO16: begin
                o_job.sub_z = gpd;
                o_job.k_val = gpd ? 16'd3 : 16'd0;
                o_job.place = PL_LO;
            end
            K_GOT16, K_MM_GOT16: begin
                o_job.y_val = 32'h0;
                o_job.z_val = i_gp_address;
                o_job.sub_z = 1'b1;
                o_job.place = PL_LO;
            end
            K_PC7: begin
                o_job.y_val = {{24{addr_a[7]}}, addr_a[7:0]};
                o_job.sub_z = 1'b1;
                o_job.place = PL_PC7;
            end
            K_PC10: begin
                o_job.y_val = {{21{addr_a[10]}}, addr_a[10:0]};
                o_job.sub_z = 1'b1;
                o_job.place = PL_PC10;
            end
            K_PC16: begin
                o_job.y_val = {{15{addr_a[16]}}, addr_a[16:0]};
                o_job.sub_z = 1'b1;
                o_job.place = PL_PC16;
            end
            K_PC23: begin
                o_job.y_val = {{7{addr_a[24]}}, addr_a[24:0]};
                o_job.sub_z = 1'b1;
                o_job.place = PL_PC23;
            end
            K_TPREL_HI16, K_MM_TPREL_HI16: begin
                o_job.k_val = HI_ROUND;
                o_job.place = PL_HI;
            end
            K_TPREL_LO16, K_MM_TPREL_LO16: begin
                o_job.place = PL_LO;
            end
            K_GPREL16: begin
                o_job.y_val = {{16{addr_a[15]}}, addr_a[15:0]};
                o_job.z_val = i_gp_address;
                o_job.sub_z = 1'b1;
                o_job.place = PL_LO;
            end
            K_GPREL32: begin
                o_job.z_val = i_gp_address;
                o_job.sub_z = 1'b1;
                o_job.place = PL_FULL;
            end
            K_ABS32HI16: begin
                o_job.k_val = HI_ROUND;
                o_job.place = PL_AHI;
            end
            K_GLOBAL_J26, K_MM_GLOBAL_J26: begin
                o_job.y_val = sh2 ? {{4{addr_a[27]}}, addr_a[27:0]}
                                  : {{5{addr_a[26]}}, addr_a[26:0]};
                o_job.place = PL_J26;
            end
            K_PLAIN_HI16: begin
                o_job.y_val = 32'h0;
                o_job.k_val = HI_ROUND;
                o_job.place = PL_HI;
            end
            K_PLAIN_LO16: begin
                o_job.y_val = 32'h0;
                o_job.place = PL_LO;
            end
            default: begin
                o_job.place = PL_KEEP;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/mrfp_queue.sv
// ----------------------------------------------------------------------------
// mrfp_queue
// Short register queue of classified requests between front and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mrfp_queue #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mrfp_pkg::t_job i_data,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output mrfp_pkg::t_job o_data
);
    import mrfp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count,  n_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not grow on push");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_pop && !do_push) |=> (r_count == $past(r_count) - 1'b1))
        else $error("queue count did not shrink on pop");

endmodule

`default_nettype wire

>>> rtl/mrfp_back.sv
// ----------------------------------------------------------------------------
// mrfp_back
// Adds the operand terms, places the value into the word, checks the pc23
// range and holds the result in an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mrfp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mrfp_pkg::t_job i_job,
    input  logic           i_job_valid,
    output logic           o_job_take,
    output logic           o_empty,
    input  logic           i_pop,
    output mrfp_pkg::t_out o_result
);
    import mrfp_pkg::*;

    logic        r_out_valid;
    t_out        r_out;
    t_out        n_out;
    logic [31:0] z_term;
    logic [31:0] sum_r;
    logic [31:0] ins;
    logic [31:0] placed;
    logic        pc23_bad;
    logic [2:0]  status;

    assign o_empty    = ~r_out_valid;
    assign o_result   = r_out;
    assign o_job_take = i_job_valid & (~r_out_valid | i_pop);

    // r = s + y - z + k, subtraction as inverted term plus carry in
    assign z_term = i_job.sub_z ? ~i_job.z_val : 32'h0;
    assign sum_r  = i_job.s_val + i_job.y_val + z_term + {16'h0, i_job.k_val}
                  + {31'h0, i_job.sub_z};
    assign ins    = i_job.ins;

    // pc23 reach is a signed 25-bit range
    assign pc23_bad = (i_job.place == PL_PC23) &&
                      (sum_r[31:24] != 8'h00) && (sum_r[31:24] != 8'hff);

    // field placement
    always_comb begin
        case (i_job.place)
            PL_KEEP: placed = ins;
            PL_FULL: placed = sum_r;
            PL_J26:  placed = i_job.sh2 ? {ins[31:26], sum_r[27:2]}
                                        : {ins[31:26], sum_r[26:1]};
            PL_HI:   placed = {ins[31:16], sum_r[31:16]};
            PL_LO:   placed = {ins[31:16], sum_r[15:0]};
            PL_PC7:  placed = {ins[31:7], sum_r[7:1]};
            PL_PC10: placed = {ins[31:10], sum_r[10:1]};
            PL_PC16: placed = {ins[31:16], sum_r[16:1]};
            PL_PC23: placed = {ins[31:23], sum_r[24:2]};
            PL_AHI:  placed = {sum_r[31:16], 16'h0000};
            default: placed = ins;
        endcase
    end

    // final status and word, swapped back for microMIPS kinds
    always_comb begin
        status = i_job.status;
        if ((status == ST_OK) && pc23_bad) begin
            status = ST_PC23_RANGE;
        end
        n_out.status = status;
        if (status != ST_OK) begin
            n_out.patched_word = i_job.word;
        end else if (i_job.swap) begin
            n_out.patched_word = {placed[15:0], placed[31:16]};
        end else begin
            n_out.patched_word = placed;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_job_take) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_take) begin
            r_out <= n_out;
        end
    end

    // checks
    a_take_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_take |=> r_out_valid)
        else $error("result register empty after taking a request");

    a_no_take_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_pop) |-> !o_job_take)
        else $error("request taken over a waiting result");

    a_pop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && r_out_valid && !o_job_take) |=> !r_out_valid)
        else $error("result register still full after pop");

endmodule

`default_nettype wire

>>> rtl/mips_reloc_field_patch.sv
// ----------------------------------------------------------------------------
// mips_reloc_field_patch
// Patches one MIPS or microMIPS instruction word per relocation request.
// A pushed request is written into the queue, then passes the back-end adder
// into the output register, which drives the result ports.
// Throughput: one request per cycle while the result register is empty or popped.
// Reset: synchronous, active low; clears the queue, the result register and
// the global pointer register. No clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mips_reloc_field_patch #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  mrfp_pkg::t_in  i_item,
    output logic           empty,
    input  logic           pop,
    output mrfp_pkg::t_out o_result,
    input  logic           i_cfg_wr_en,
    input  logic [31:0]    i_cfg_wr_data
);
    import mrfp_pkg::*;

    logic [31:0] r_gp_address;
    t_job        front_job;
    t_job        queue_job;
    logic        queue_valid;
    logic        back_take;

    // global pointer register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gp_address <= 32'h0;
        end else if (i_cfg_wr_en) begin
            r_gp_address <= i_cfg_wr_data;
        end
    end

    // front end: classify the incoming request
    mrfp_front u_front (
        .i_item       (i_item),
        .i_gp_address (r_gp_address),
        .o_job        (front_job)
    );

    // decoupling queue
    mrfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_job),
        .o_full  (full),
        .o_valid (queue_valid),
        .i_pop   (back_take),
        .o_data  (queue_job)
    );

    // back end: compute and hold the result
    mrfp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (queue_job),
        .i_job_valid (queue_valid),
        .o_job_take  (back_take),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire
